// ----- rtl/core/fag_pkg.sv -----
// Shared types, constants and helpers for the fraction accumulator.
// No dependencies; used by fag_alu and fraction_accumulator_gcd_reduce_top.
`timescale 1ns / 1ps

package fag_pkg;

    localparam int VALUE_W = 32;                  // state width, 8..64
    localparam int IO_W    = 32;                  // port width of values
    localparam int KIND_W  = 3;
    localparam int CNT_W   = $clog2(VALUE_W + 1);
    localparam int ADD_W   = VALUE_W + 2;         // shared adder width

    localparam logic [KIND_W-1:0] KIND_LOAD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;

    localparam logic signed [64:0] VMAX_X = (65'sd1 <<< (VALUE_W - 1)) - 65'sd1;
    localparam logic signed [64:0] VMIN_X = -VMAX_X - 65'sd1;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic               start;
        t_alu_op            op;
        logic [VALUE_W-1:0] a;      // multiplicand or dividend
        logic [VALUE_W-1:0] b;      // multiplier or divisor
    } t_alu_req;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] hi;     // product high half or remainder
        logic [VALUE_W-1:0] lo;     // product low half or quotient
    } t_alu_rsp;

    // magnitude of a two's complement value; most negative maps to 2^(W-1)
    function automatic logic [VALUE_W-1:0] mag(input logic [VALUE_W-1:0] v);
        return v[VALUE_W-1] ? (~v + {{(VALUE_W-1){1'b0}}, 1'b1}) : v;
    endfunction

    function automatic logic fits_val(input logic [IO_W-1:0] x);
        logic signed [64:0] e;
        e = 65'(signed'(x));
        return (e >= VMIN_X) && (e <= VMAX_X);
    endfunction

    function automatic logic [VALUE_W-1:0] to_val(input logic [IO_W-1:0] x);
        logic signed [64:0] e;
        e = 65'(signed'(x));
        return e[VALUE_W-1:0];
    endfunction

    function automatic logic [IO_W-1:0] to_io(input logic [VALUE_W-1:0] v);
        logic signed [64:0] e;
        e = 65'(signed'(v));
        return e[IO_W-1:0];
    endfunction

endpackage

// ----- rtl/core/fag_alu.sv -----
// Bit-serial unsigned multiply / restoring divide around one shared adder.
// Depends on fag_pkg. One bit per cycle.
`timescale 1ns / 1ps

module fag_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fag_pkg::t_alu_req i_req,
    output fag_pkg::t_alu_rsp o_rsp
);

    localparam int W = fag_pkg::VALUE_W;
    localparam int A = fag_pkg::ADD_W;

    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    fag_pkg::t_alu_op         r_op, n_op;
    logic [fag_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]             r_hi, n_hi;
    logic [W-1:0]             r_lo, n_lo;
    logic [W-1:0]             r_m, n_m;

    logic [A-1:0] opx, opy, sum;
    logic         sub;

    // shared adder
    always_comb begin
        if (r_op == fag_pkg::ALU_DIV) begin
            opx = {1'b0, r_hi, r_lo[W-1]};
            opy = {2'b00, r_m};
            sub = 1'b1;
        end else begin
            opx = {2'b00, r_hi};
            opy = r_lo[0] ? {2'b00, r_m} : '0;
            sub = 1'b0;
        end
        sum = opx + (sub ? ~opy : opy) + {{(A-1){1'b0}}, sub};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_m    = r_m;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = fag_pkg::CNT_W'(W);
            n_hi   = '0;
            if (i_req.op == fag_pkg::ALU_DIV) begin
                n_lo = i_req.a;
                n_m  = i_req.b;
            end else begin
                n_lo = i_req.b;
                n_m  = i_req.a;
            end
        end else if (r_busy) begin
            if (r_op == fag_pkg::ALU_DIV) begin
                if (!sum[A-1]) begin
                    n_hi = sum[W-1:0];
                    n_lo = {r_lo[W-2:0], 1'b1};
                end else begin
                    n_hi = opx[W-1:0];
                    n_lo = {r_lo[W-2:0], 1'b0};
                end
            end else begin
                n_hi = sum[W:1];
                n_lo = {sum[0], r_lo[W-1:1]};
            end
            n_cnt = r_cnt - fag_pkg::CNT_W'(1);
            if (r_cnt == fag_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= fag_pkg::ALU_MUL;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_hi <= n_hi;
        r_lo <= n_lo;
        r_m  <= n_m;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hi   = r_hi;
    assign o_rsp.lo   = r_lo;

endmodule

// ----- rtl/core/fraction_accumulator_gcd_reduce_top.sv -----
// Fraction accumulator with remainder-chain gcd reduction: sequencer and state.
// Depends on fag_pkg and fag_alu (shared serial multiply/divide unit).
//
//  channel | direction | handshake                 | payload
//  in      | request   | i_in_valid / o_in_ready   | i_kind, i_operand, i_load_denominator
//  out     | result    | o_out_valid / i_out_ready | o_numerator_out, o_denominator_out,
//          |           |                           | o_overflow
//
// An item uses at most one multiply in fag_alu, one divide per Euclid step (up to
// about 1.44 * VALUE_W steps) and two divides for the reduction.
// Reset (synchronous, active low) sets the fraction to 0/1 and empties the output.
// o_in_ready is high only while no request is in work; a held result does not stall
// the next request until that one is ready to be written out.
`timescale 1ns / 1ps

module fraction_accumulator_gcd_reduce_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [fag_pkg::KIND_W-1:0]  i_kind,
    input  logic signed [fag_pkg::IO_W-1:0] i_operand,
    input  logic signed [fag_pkg::IO_W-1:0] i_load_denominator,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [fag_pkg::IO_W-1:0] o_numerator_out,
    output logic signed [fag_pkg::IO_W-1:0] o_denominator_out,
    output logic                        o_overflow
);

    localparam int W = fag_pkg::VALUE_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_ADD  = 8'b0000_0100,
        S_GCD  = 8'b0000_1000,
        S_REM  = 8'b0001_0000,
        S_DIVN = 8'b0010_0000,
        S_DIVD = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state                      r_state, n_state;
    logic [fag_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [W-1:0]                r_top, n_top;
    logic [W-1:0]                r_bot, n_bot;
    logic [W-1:0]                r_n, n_n;
    logic [W-1:0]                r_d, n_d;
    logic [W-1:0]                r_a, n_a;      // gcd chain
    logic [W-1:0]                r_b, n_b;
    logic [W-1:0]                r_x, n_x;      // operand, later product
    logic                        r_neg, n_neg;
    logic                        r_ok, n_ok;
    fag_pkg::t_alu_req           r_req, n_req;
    fag_pkg::t_alu_rsp           alu_rsp;
    logic                        r_o_valid, n_o_valid;
    logic [fag_pkg::IO_W-1:0]    r_o_num, n_o_num;
    logic [fag_pkg::IO_W-1:0]    r_o_den, n_o_den;
    logic                        r_o_ovf, n_o_ovf;

    logic [2*W-1:0] prod;
    logic [W:0]     prod_hi;
    logic           prod_fit;
    logic [W-1:0]   prod_val;
    logic [W:0]     as_sum;
    logic [W-1:0]   quo_val;
    logic           quo_fit;
    logic [W-1:0]   rem_val;

    fag_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (alu_rsp)
    );

    always_comb begin
        prod     = {alu_rsp.hi, alu_rsp.lo};
        prod_hi  = prod[2*W-1:W-1];
        // negative result may reach exactly 2^(W-1)
        prod_fit = (prod_hi == '0) ||
                   (r_neg && prod_hi == {{W{1'b0}}, 1'b1} && prod[W-2:0] == '0);
        prod_val = r_neg ? (~prod[W-1:0] + {{(W-1){1'b0}}, 1'b1}) : prod[W-1:0];
        if (r_kind == fag_pkg::KIND_SUB)
            as_sum = {r_n[W-1], r_n} - {r_x[W-1], r_x};
        else
            as_sum = {r_n[W-1], r_n} + {r_x[W-1], r_x};
        quo_fit  = r_neg || !alu_rsp.lo[W-1];
        quo_val  = r_neg ? (~alu_rsp.lo + {{(W-1){1'b0}}, 1'b1}) : alu_rsp.lo;
        // truncating remainder takes the dividend's sign
        rem_val  = r_a[W-1] ? (~alu_rsp.hi + {{(W-1){1'b0}}, 1'b1}) : alu_rsp.hi;
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_top     = r_top;
        n_bot     = r_bot;
        n_n       = r_n;
        n_d       = r_d;
        n_a       = r_a;
        n_b       = r_b;
        n_x       = r_x;
        n_neg     = r_neg;
        n_ok      = r_ok;
        n_req     = '0;
        n_req.op  = fag_pkg::ALU_MUL;
        n_o_valid = r_o_valid && !i_out_ready;
        n_o_num   = r_o_num;
        n_o_den   = r_o_den;
        n_o_ovf   = r_o_ovf;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind = i_kind;
                    n_x    = fag_pkg::to_val(i_operand);
                    n_n    = r_top;
                    n_d    = r_bot;
                    n_a    = r_top;
                    n_b    = r_bot;
                    n_ok   = 1'b1;
                    n_state = S_GCD;
                    case (i_kind)
                        fag_pkg::KIND_LOAD: begin
                            if (fag_pkg::fits_val(i_operand) &&
                                fag_pkg::fits_val(i_load_denominator)) begin
                                n_n = fag_pkg::to_val(i_operand);
                                n_d = fag_pkg::to_val(i_load_denominator);
                                n_a = fag_pkg::to_val(i_operand);
                                n_b = fag_pkg::to_val(i_load_denominator);
                            end else begin
                                n_ok    = 1'b0;
                                n_state = S_FIN;
                            end
                        end
                        fag_pkg::KIND_ADD, fag_pkg::KIND_SUB, fag_pkg::KIND_MUL,
                        fag_pkg::KIND_DIV: begin
                            if (!fag_pkg::fits_val(i_operand)) begin
                                n_ok    = 1'b0;
                                n_state = S_FIN;
                            end else begin
                                n_req.start = 1'b1;
                                n_req.op    = fag_pkg::ALU_MUL;
                                n_req.b     = fag_pkg::mag(fag_pkg::to_val(i_operand));
                                if (i_kind == fag_pkg::KIND_MUL) begin
                                    n_req.a = fag_pkg::mag(r_top);
                                    n_neg   = r_top[W-1] ^ i_operand[fag_pkg::IO_W-1];
                                end else begin
                                    n_req.a = fag_pkg::mag(r_bot);
                                    n_neg   = r_bot[W-1] ^ i_operand[fag_pkg::IO_W-1];
                                end
                                n_state = S_MUL;
                            end
                        end
                        default: begin
                            // unknown kind: reduce only
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (alu_rsp.done) begin
                    if (!prod_fit) begin
                        n_ok    = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        case (r_kind)
                            fag_pkg::KIND_MUL: begin
                                n_n     = prod_val;
                                n_a     = prod_val;
                                n_state = S_GCD;
                            end
                            fag_pkg::KIND_DIV: begin
                                n_d     = prod_val;
                                n_b     = prod_val;
                                n_state = S_GCD;
                            end
                            default: begin
                                n_x     = prod_val;
                                n_state = S_ADD;
                            end
                        endcase
                    end
                end
            end
            S_ADD: begin
                if (as_sum[W] != as_sum[W-1]) begin
                    n_ok    = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_n     = as_sum[W-1:0];
                    n_a     = as_sum[W-1:0];
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (r_b == '0) begin
                    if (r_a == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_req.start = 1'b1;
                        n_req.op    = fag_pkg::ALU_DIV;
                        n_req.a     = fag_pkg::mag(r_n);
                        n_req.b     = fag_pkg::mag(r_a);
                        n_neg       = r_n[W-1] ^ r_a[W-1];
                        n_state     = S_DIVN;
                    end
                end else begin
                    n_req.start = 1'b1;
                    n_req.op    = fag_pkg::ALU_DIV;
                    n_req.a     = fag_pkg::mag(r_a);
                    n_req.b     = fag_pkg::mag(r_b);
                    n_state     = S_REM;
                end
            end
            S_REM: begin
                if (alu_rsp.done) begin
                    n_a     = r_b;
                    n_b     = rem_val;
                    n_state = S_GCD;
                end
            end
            S_DIVN: begin
                if (alu_rsp.done) begin
                    if (!quo_fit) begin
                        n_ok    = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        n_n         = quo_val;
                        n_req.start = 1'b1;
                        n_req.op    = fag_pkg::ALU_DIV;
                        n_req.a     = fag_pkg::mag(r_d);
                        n_req.b     = fag_pkg::mag(r_a);
                        n_neg       = r_d[W-1] ^ r_a[W-1];
                        n_state     = S_DIVD;
                    end
                end
            end
            S_DIVD: begin
                if (alu_rsp.done) begin
                    if (!quo_fit) begin
                        n_ok = 1'b0;
                    end else begin
                        n_d = quo_val;
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // wait for the output register to be free
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid = 1'b1;
                    n_o_ovf   = !r_ok;
                    if (r_ok) begin
                        n_top   = r_n;
                        n_bot   = r_d;
                        n_o_num = fag_pkg::to_io(r_n);
                        n_o_den = fag_pkg::to_io(r_d);
                    end else begin
                        n_o_num = fag_pkg::to_io(r_top);
                        n_o_den = fag_pkg::to_io(r_bot);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_top     <= '0;
            r_bot     <= {{(W-1){1'b0}}, 1'b1};
            r_req     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_top     <= n_top;
            r_bot     <= n_bot;
            r_req     <= n_req;
            r_o_valid <= n_o_valid;
        end
        r_kind  <= n_kind;
        r_n     <= n_n;
        r_d     <= n_d;
        r_a     <= n_a;
        r_b     <= n_b;
        r_x     <= n_x;
        r_neg   <= n_neg;
        r_ok    <= n_ok;
        r_o_num <= n_o_num;
        r_o_den <= n_o_den;
        r_o_ovf <= n_o_ovf;
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_o_valid;
    assign o_numerator_out   = r_o_num;
    assign o_denominator_out = r_o_den;
    assign o_overflow        = r_o_ovf;

endmodule
